@@ rtl/wcsd_pkg.sv @@
// shared types, constants and the sample quantizer of the charge switch
package wcsd_pkg;

   // window geometry
   localparam int WINDOW_SAMPLES = 10;
   localparam int SLOT_W         = $clog2(WINDOW_SAMPLES);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SAMPLES - 1);

   // field widths
   localparam int SAMPLE_W  = 10;
   localparam int DIGIT_W   = 3;
   localparam int COUNT_W   = 8;
   localparam int PATTERN_W = 9;

   // register file
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic REG_ON_THRESHOLD = 1'b0;
   localparam logic REG_HOLD_OFF     = 1'b1;
   localparam logic [DIGIT_W-1:0] ON_THRESHOLD_RESET = 3'd4;
   localparam logic [COUNT_W-1:0] HOLD_OFF_RESET     = 8'd10;

   // classified sample handed from the front to the back
   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               dot;
      logic               high;
   } item_type;

   // one result word
   typedef struct packed {
      logic                 write;
      logic                 mode;
      logic [DIGIT_W-1:0]   digit;
      logic                 dot;
      logic [PATTERN_W-1:0] pattern;
      logic                 charge;
      logic                 hold;
   } result_type;

   // half-volt quantizer: {digit, dot}
   function automatic logic [DIGIT_W:0] quantize(input logic [SAMPLE_W-1:0] s);
      logic [DIGIT_W:0] q;
      if (s >= 10'd1000)     q = {3'd5, 1'b0};
      else if (s >= 10'd921) q = {3'd4, 1'b1};
      else if (s >= 10'd820) q = {3'd4, 1'b0};
      else if (s >= 10'd716) q = {3'd3, 1'b1};
      else if (s >= 10'd615) q = {3'd3, 1'b0};
      else if (s >= 10'd512) q = {3'd2, 1'b1};
      else if (s >= 10'd410) q = {3'd2, 1'b0};
      else if (s >= 10'd307) q = {3'd1, 1'b1};
      else if (s >= 10'd205) q = {3'd1, 1'b0};
      else if (s >= 10'd102) q = {3'd0, 1'b1};
      else                   q = {3'd0, 1'b0};
      return q;
   endfunction

endpackage

@@ rtl/wcsd_front.sv @@
// front end: quantizes a sample and classifies it against the on threshold
module wcsd_front
   import wcsd_pkg::*;
(
   input  logic [SAMPLE_W-1:0] adc_sample,
   input  logic [DIGIT_W-1:0]  on_digit_threshold,
   output item_type            item
);

   logic [DIGIT_W:0] quant;

   // digit and dot, then the high flag
   always_comb begin
      quant      = quantize(adc_sample);
      item.digit = quant[DIGIT_W:1];
      item.dot   = quant[0];
      item.high  = (quant[DIGIT_W:1] >= on_digit_threshold);
   end

endmodule

@@ rtl/wcsd_queue.sv @@
// two-entry queue of classified samples between front and back
module wcsd_queue
   import wcsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   item_type   mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_item = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/wcsd_back.sv @@
// back end: window history, charge switch, hold-off, display command and result queue
module wcsd_back
   import wcsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  item_type           in_item,
   input  logic               in_empty,
   output logic               in_pop,
   input  logic [COUNT_W-1:0] hold_off_windows,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output result_type         rsp_result
);

   localparam logic [WINDOW_SAMPLES-1:0] ALL_HIGH = '1;

   // processing state
   logic [WINDOW_SAMPLES-1:0] history_ff, history_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [COUNT_W-1:0]        hold_count_ff, hold_count_in;
   logic                      hold_ff, hold_in;
   logic                      loader_ff, loader_in;
   logic                      charging_ff, charging_in;
   logic                      last_valid_ff, last_valid_in;
   logic [DIGIT_W-1:0]        last_digit_ff, last_digit_in;
   logic                      last_dot_ff, last_dot_in;

   // result queue
   result_type mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       take, do_pop;
   result_type res;
   logic       all_high, all_low, can_start;

   assign take       = !in_empty && (count_ff != 2'd2);
   assign in_pop     = take;
   assign do_pop     = rsp_pop && (count_ff != 2'd0);
   assign rsp_empty  = (count_ff == 2'd0);
   assign rsp_result = mem_ff[rd_ptr_ff];

   // per-word state update and result
   always_comb begin
      history_in    = history_ff;
      slot_in       = slot_ff;
      hold_count_in = hold_count_ff;
      hold_in       = hold_ff;
      loader_in     = loader_ff;
      charging_in   = charging_ff;
      last_valid_in = last_valid_ff;
      last_digit_in = last_digit_ff;
      last_dot_in   = last_dot_ff;
      res           = '0;
      all_high      = 1'b0;
      all_low       = 1'b0;
      can_start     = 1'b0;

      if (take) begin
         history_in[slot_ff] = in_item.high;

         // display command
         if (loader_ff) begin
            res.write     = 1'b1;
            res.mode      = 1'b1;
            for (int i = 0; i < PATTERN_W; i++) begin
               res.pattern[i] = (int'(slot_ff) == i + 1);
            end
            last_valid_in = 1'b0;
            last_digit_in = '0;
            last_dot_in   = 1'b0;
         end else begin
            res.digit = in_item.digit;
            res.dot   = in_item.dot;
            if (!last_valid_ff || in_item.digit != last_digit_ff
                || in_item.dot != last_dot_ff) begin
               res.write     = 1'b1;
               last_valid_in = 1'b1;
               last_digit_in = in_item.digit;
               last_dot_in   = in_item.dot;
            end
         end

         // window end decision
         if (slot_ff >= LAST_SLOT) begin
            all_high  = (history_in == ALL_HIGH);
            all_low   = (history_in == '0);
            can_start = !charging_ff && all_high;
            if (!hold_ff && can_start) begin
               loader_in   = 1'b0;
               charging_in = 1'b1;
            end else if (hold_ff && can_start) begin
               loader_in = 1'b1;
            end else if (hold_ff) begin
               loader_in = 1'b0;
            end else if (charging_ff && all_low) begin
               charging_in   = 1'b0;
               hold_in       = 1'b1;
               hold_count_in = '0;
            end
            if (hold_in) begin
               if (hold_count_in == hold_off_windows) begin
                  hold_in   = 1'b0;
                  loader_in = 1'b0;
               end else begin
                  hold_count_in = hold_count_in + 1'b1;
               end
            end
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end

         res.charge = charging_in;
         res.hold   = hold_in;
      end
   end

   // result queue fill count
   always_comb begin
      count_in = count_ff + {1'b0, take} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff    <= '0;
         slot_ff       <= '0;
         hold_count_ff <= '0;
         hold_ff       <= 1'b0;
         loader_ff     <= 1'b0;
         charging_ff   <= 1'b0;
         last_valid_ff <= 1'b0;
         last_digit_ff <= '0;
         last_dot_ff   <= 1'b0;
         count_ff      <= 2'd0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
      end else begin
         history_ff    <= history_in;
         slot_ff       <= slot_in;
         hold_count_ff <= hold_count_in;
         hold_ff       <= hold_in;
         loader_ff     <= loader_in;
         charging_ff   <= charging_in;
         last_valid_ff <= last_valid_in;
         last_digit_ff <= last_digit_in;
         last_dot_ff   <= last_dot_in;
         count_ff      <= count_in;
         wr_ptr_ff     <= wr_ptr_ff ^ take;
         rd_ptr_ff     <= rd_ptr_ff ^ do_pop;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (take) begin
         mem_ff[wr_ptr_ff] <= res;
      end
   end

`ifndef NO_ASSERTIONS
   // loader only runs inside a hold-off
   assert property (@(posedge clock) disable iff (reset) loader_ff |-> hold_ff)
      else $error("loader active outside hold-off");
   // hold-off only follows switching off
   assert property (@(posedge clock) disable iff (reset) hold_ff |-> !charging_ff)
      else $error("charging during hold-off");
   // a loader word always writes the display
   assert property (@(posedge clock) disable iff (reset) (take && res.mode) |-> res.write)
      else $error("loader word without display write");
   // a stored result is visible next cycle
   assert property (@(posedge clock) disable iff (reset) take |=> !rsp_empty)
      else $error("result lost after store");
`endif

endmodule

@@ rtl/windowed_charge_switch_with_display.sv @@
// top level: register file, front classifier, sample queue and back end
//
// Usage:
//   Samples enter as words on req_adc_sample, taken at a clock edge with push
//   high and full low. Every sample yields exactly one result word, shown on
//   the rsp_ ports while empty is low and taken at an edge with pop high.
//   A word accepted at an edge is classified and written into a two-entry
//   sample queue; the back end takes a queued sample whenever its two-entry
//   result queue has room and moves it there. One word per cycle is sustained
//   in both directions while the receiver does not stall.
//   When the receiver stalls, the result queue and then the sample queue fill
//   and full rises; nothing is dropped. The registers (on threshold at byte
//   address 0, hold-off windows at 4) are written over the APB port and
//   should be changed only while no word is in flight.
//   Synchronous reset empties both queues, clears the window history, the
//   charge switch, the hold-off and the stored display value, and loads the
//   register reset values (threshold 4, hold-off 10 windows).
module windowed_charge_switch_with_display
   import wcsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // sample channel
   input  logic                 push,
   output logic                 full,
   input  logic [SAMPLE_W-1:0]  req_adc_sample,
   // result channel
   output logic                 empty,
   input  logic                 pop,
   output logic                 rsp_display_write,
   output logic                 rsp_display_mode,
   output logic [DIGIT_W-1:0]   rsp_shown_digit,
   output logic                 rsp_shown_dot,
   output logic [PATTERN_W-1:0] rsp_loader_pattern,
   output logic                 rsp_charge_enable,
   output logic                 rsp_in_hold_off,
   // register port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [DATA_W-1:0]    pwdata,
   output logic [DATA_W-1:0]    prdata,
   output logic                 pready
);

   logic [DIGIT_W-1:0] on_threshold_ff;
   logic [COUNT_W-1:0] hold_off_ff;
   logic               reg_write;
   logic               reg_index;
   item_type           front_item;
   item_type           queue_item;
   logic               queue_empty;
   logic               queue_pop;
   result_type         result;

   // register access
   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite && pready;
   assign reg_index = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         on_threshold_ff <= ON_THRESHOLD_RESET;
         hold_off_ff     <= HOLD_OFF_RESET;
      end else if (reg_write) begin
         case (reg_index)
            REG_ON_THRESHOLD: on_threshold_ff <= pwdata[DIGIT_W-1:0];
            REG_HOLD_OFF:     hold_off_ff     <= pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (reg_index)
         REG_ON_THRESHOLD: prdata = {{(DATA_W-DIGIT_W){1'b0}}, on_threshold_ff};
         REG_HOLD_OFF:     prdata = {{(DATA_W-COUNT_W){1'b0}}, hold_off_ff};
         default:          prdata = '0;
      endcase
   end

   // classification
   wcsd_front u_front (
      .adc_sample         (req_adc_sample),
      .on_digit_threshold (on_threshold_ff),
      .item               (front_item)
   );

   // sample queue
   wcsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (full),
      .pop       (queue_pop),
      .pop_item  (queue_item),
      .empty     (queue_empty)
   );

   // state update and result queue
   wcsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .in_item          (queue_item),
      .in_empty         (queue_empty),
      .in_pop           (queue_pop),
      .hold_off_windows (hold_off_ff),
      .rsp_pop          (pop),
      .rsp_empty        (empty),
      .rsp_result       (result)
   );

   // result fields
   assign rsp_display_write  = result.write;
   assign rsp_display_mode   = result.mode;
   assign rsp_shown_digit    = result.digit;
   assign rsp_shown_dot      = result.dot;
   assign rsp_loader_pattern = result.pattern;
   assign rsp_charge_enable  = result.charge;
   assign rsp_in_hold_off    = result.hold;

endmodule
